// ===== rtl/toy_register_machine_executor_macros.svh =====
// Assertion macros for the register machine executor.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TOY_REGISTER_MACHINE_EXECUTOR_MACROS_SVH
`define TOY_REGISTER_MACHINE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TRME_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, disabled while in reset.
`define TRME_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/trme_pkg.sv =====
// Shared types and constants of the register machine executor.
// No dependencies; imported by every module of the block.
`default_nettype none

package trme_pkg;

    localparam int DATA_W  = 32;
    localparam int REG_AW  = 3;
    localparam int IMM_W   = 6;
    localparam int DIV_STEPS = 32;
    localparam int STEP_CW = 5;

    localparam logic [3:0] OP_CLEAR = 4'b0000;
    localparam logic [3:0] OP_HALT  = 4'b0001;
    localparam logic [3:0] OP_LOADI = 4'b0011;
    localparam logic [3:0] OP_ADD   = 4'b0101;
    localparam logic [3:0] OP_SUB   = 4'b0111;
    localparam logic [3:0] OP_IN_A  = 4'b1000;
    localparam logic [3:0] OP_MUL   = 4'b1010;
    localparam logic [3:0] OP_DIV   = 4'b1100;
    localparam logic [3:0] OP_IN_B  = 4'b1101;
    localparam logic [3:0] OP_OUT   = 4'b1111;

    typedef struct packed {
        logic [3:0]               opcode;
        logic [REG_AW-1:0]        src_a;
        logic [REG_AW-1:0]        src_b;
        logic [REG_AW-1:0]        dest;
        logic [IMM_W-1:0]         immediate;
        logic signed [DATA_W-1:0] user_value;
    } cmd_t;

    typedef struct packed {
        logic                     out_valid;
        logic signed [DATA_W-1:0] out_value;
        logic                     halted;
        logic                     div_zero;
    } rsp_t;

    // Register file write port: single entry write or clear of every entry.
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/trme_regfile.sv =====
// Eight-entry register file: synchronous memory with two registered read ports.
// Per-entry valid bits give the all-zero reset and the clear of every entry. Uses trme_pkg.
`default_nettype none

module trme_regfile (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [trme_pkg::REG_AW-1:0]   rd_addr_a,
    input  wire logic [trme_pkg::REG_AW-1:0]   rd_addr_b,
    input  wire trme_pkg::rf_wr_t              wr,
    output logic [trme_pkg::DATA_W-1:0]        rd_data_a,
    output logic [trme_pkg::DATA_W-1:0]        rd_data_b
);
    import trme_pkg::*;

    localparam int DEPTH = 1 << REG_AW;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] data_a_reg;
    logic [DATA_W-1:0] data_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear)
            begin
                vld_reg <= '0;
            end
            else if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg <= vld_reg[rd_addr_a];
                vld_b_reg <= vld_reg[rd_addr_b];
            end
        end
    end

    // Entries never written since reset or clear read as zero
    assign rd_data_a = vld_a_reg ? data_a_reg : '0;
    assign rd_data_b = vld_b_reg ? data_b_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/trme_sdiv.sv =====
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// Restoring division on magnitudes; divisor must be non-zero. Uses trme_pkg.
`default_nettype none

module trme_sdiv (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trme_pkg::div_req_t req,
    output trme_pkg::div_rsp_t      rsp
);
    import trme_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_CW-1:0]  cnt_reg;
    logic [DATA_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   dvs_reg;
    logic                neg_reg;

    logic                neg_a;
    logic                neg_b;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     trial;
    logic                ge;
    logic                last_step;

    assign neg_a = req.dividend[DATA_W-1];
    assign neg_b = req.divisor[DATA_W-1];
    assign mag_a = neg_a ? (DATA_W'(0) - req.dividend) : req.dividend;
    assign mag_b = neg_b ? (DATA_W'(0) - req.divisor) : req.divisor;

    assign shifted   = {rem_reg, quo_reg[DATA_W-1]};
    assign trial     = shifted - {1'b0, dvs_reg};
    assign ge        = (shifted >= {1'b0, dvs_reg});
    assign last_step = (cnt_reg == STEP_CW'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + STEP_CW'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= mag_a;
            rem_reg <= '0;
            dvs_reg <= mag_b;
            neg_reg <= neg_a ^ neg_b;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_reg <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// ===== rtl/toy_register_machine_executor.sv =====
// Register machine executor: top level with the instruction sequencer.
// Depends on trme_pkg, trme_regfile, trme_sdiv and the assertion macro header.
//
// Usage:
//   cmd channel (cmd_valid / cmd_ready / cmd) takes one decoded instruction per
//   beat; rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one result
//   beat per instruction, in order.
//   One instruction is in flight at a time. Both source registers are read from
//   the register file memory on the accept edge (registered read), then come the
//   execute state and the write-back state, after which cmd_ready returns. A divide
//   with a non-zero divisor adds the serial divider between them: its 32 steps, then
//   its registered done flag.
//   The result sits in an output register; the next instruction is taken while
//   it waits. If rsp_ready stays low, the following instruction stalls in its
//   write-back cycle until the output register frees up.
//   Reset clears the halt flag, all register valid bits (registers read as
//   zero) and both channels' control; no clearing pass is needed.
//   After a halt every instruction returns halted with no other effect.
`default_nettype none

`include "toy_register_machine_executor_macros.svh"

module toy_register_machine_executor (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire trme_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output trme_pkg::rsp_t      rsp
);
    import trme_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        state_reg,  state_next;
    cmd_t              cmd_reg;
    logic              halt_reg,   halt_next;
    logic [DATA_W-1:0] res_reg,    res_next;
    logic              wr_reg,     wr_next;
    logic [REG_AW-1:0] wr_addr_reg, wr_addr_next;
    logic              clr_reg,    clr_next;
    logic              show_reg,   show_next;
    logic              dz_reg,     dz_next;
    logic              hset_reg,   hset_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    logic              accept;
    logic              retire;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] product;
    rf_wr_t            rf_wr;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign retire    = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);
    assign product   = va * vb;

    trme_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (cmd.src_a),
        .rd_addr_b (cmd.src_b),
        .wr        (rf_wr),
        .rd_data_a (va),
        .rd_data_b (vb)
    );

    trme_sdiv u_sdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        wr_next      = wr_reg;
        wr_addr_next = wr_addr_reg;
        clr_next     = clr_reg;
        show_next    = show_reg;
        dz_next      = dz_reg;
        hset_next    = hset_reg;
        halt_next    = halt_reg;
        div_req.start    = 1'b0;
        div_req.dividend = va;
        div_req.divisor  = vb;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_next     = '0;
                wr_next      = 1'b0;
                wr_addr_next = cmd_reg.dest;
                clr_next     = 1'b0;
                show_next    = 1'b0;
                dz_next      = 1'b0;
                hset_next    = 1'b0;
                state_next   = ST_FIN;
                if (!halt_reg)
                begin
                    unique case (cmd_reg.opcode)
                        OP_LOADI:
                        begin
                            res_next = DATA_W'(cmd_reg.immediate);
                            wr_next  = 1'b1;
                        end
                        OP_ADD:
                        begin
                            res_next = va + vb;
                            wr_next  = 1'b1;
                        end
                        OP_SUB:
                        begin
                            res_next = va - vb;
                            wr_next  = 1'b1;
                        end
                        OP_MUL:
                        begin
                            res_next = product;
                            wr_next  = 1'b1;
                        end
                        OP_DIV:
                        begin
                            wr_next = 1'b1;
                            if (vb == '0)
                            begin
                                dz_next = 1'b1;
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        OP_IN_A, OP_IN_B:
                        begin
                            res_next     = $unsigned(cmd_reg.user_value);
                            wr_next      = 1'b1;
                            wr_addr_next = cmd_reg.src_a;
                        end
                        OP_OUT:
                        begin
                            res_next  = va;
                            show_next = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            clr_next = 1'b1;
                        end
                        OP_HALT:
                        begin
                            hset_next = 1'b1;
                        end
                        default:
                        begin
                            // unknown opcode: no effect
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = div_rsp.quotient;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (retire)
                begin
                    halt_next  = halt_reg | hset_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Write back in the same cycle the result beat is loaded
    assign rf_wr.en    = retire && wr_reg;
    assign rf_wr.clear = retire && clr_reg;
    assign rf_wr.addr  = wr_addr_reg;
    assign rf_wr.data  = res_reg;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (retire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            halt_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halt_reg      <= halt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        res_reg     <= res_next;
        wr_reg      <= wr_next;
        wr_addr_reg <= wr_addr_next;
        clr_reg     <= clr_next;
        show_reg    <= show_next;
        dz_reg      <= dz_next;
        hset_reg    <= hset_next;
        if (retire)
        begin
            rsp_reg.out_valid <= show_reg;
            rsp_reg.out_value <= show_reg ? $signed(res_reg) : '0;
            rsp_reg.halted    <= halt_reg | hset_reg;
            rsp_reg.div_zero  <= dz_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TRME_ASSERT_NEVER(a_halt_sticky, $fell(halt_reg), "halt flag dropped without reset")
    `TRME_ASSERT_IMPL(a_halted_quiet, rsp_valid && rsp.halted,
        !rsp.out_valid && !rsp.div_zero, "halted beat carries an effect")
    `TRME_ASSERT_IMPL(a_div_done_state, div_rsp.done, state_reg == ST_DIV,
        "divider finished outside the divide wait")
    `TRME_ASSERT_IMPL(a_rf_write_retire, rf_wr.en || rf_wr.clear,
        state_reg == ST_FIN && !halt_reg, "register file written outside write-back")

endmodule

`default_nettype wire

// ===== tb/toy_register_machine_executor_tb.sv =====
// Self-checking testbench for the register machine executor: directed rows, then random
// instruction streams, closing rows; a shadow register file predicts every result beat.
// Depends on trme_pkg and the toy_register_machine_executor RTL.
`timescale 1ns / 1ps

module toy_register_machine_executor_tb;
    import trme_pkg::*;

    localparam int N_RANDOM   = 1400;
    localparam int N_PRE      = 22;
    localparam int N_PLAN     = 26;
    localparam int DRAIN_WAIT = 40;
    localparam int PRINT_CAP  = 60;

    // Opcodes that the block must ignore.
    localparam logic [5:0][3:0] OP_SPARE = {4'b1110, 4'b1011, 4'b1001,
                                            4'b0110, 4'b0100, 4'b0010};

    localparam rsp_t SHOW_ZERO    = '{out_valid: 1'b1, out_value: '0, halted: 1'b0,
                                      div_zero: 1'b0};
    localparam rsp_t DIV_BY_ZERO  = '{out_valid: 1'b0, out_value: '0, halted: 1'b0,
                                      div_zero: 1'b1};
    localparam rsp_t HALTED_ONLY  = '{out_valid: 1'b0, out_value: '0, halted: 1'b1,
                                      div_zero: 1'b0};

    typedef struct packed {
        cmd_t c;
        logic fixed;
        rsp_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic [DATA_W-1:0] shadow_regs [8];
    bit                shadow_halted;
    rsp_t              pending_results [$];
    plan_row_t         plan [N_PLAN];
    rsp_t              oldest;
    int                mismatches;
    int                results_seen;
    bit                calm_phase;

    toy_register_machine_executor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d: %0s got %h want %h", $time, results_seen, what,
                     got, want);
        mismatches++;
    endtask

    function automatic cmd_t instr(input logic [3:0] op, input int a, input int b,
                                   input int d, input int imm, input logic [31:0] uv);
        cmd_t c;
        c.opcode     = op;
        c.src_a      = a[REG_AW-1:0];
        c.src_b      = b[REG_AW-1:0];
        c.dest       = d[REG_AW-1:0];
        c.immediate  = imm[IMM_W-1:0];
        c.user_value = uv;
        return c;
    endfunction

    // Execute one instruction on the shadow state and return the result beat it yields.
    function automatic rsp_t exec_instruction(input cmd_t c);
        rsp_t              r;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        longint            quot;
        r = '0;
        if (!shadow_halted)
        begin
            va = shadow_regs[c.src_a];
            vb = shadow_regs[c.src_b];
            case (c.opcode)
                OP_LOADI: shadow_regs[c.dest] = DATA_W'(c.immediate);
                OP_ADD:   shadow_regs[c.dest] = va + vb;
                OP_SUB:   shadow_regs[c.dest] = va - vb;
                OP_MUL:   shadow_regs[c.dest] = va * vb;
                OP_DIV:
                begin
                    if (vb == '0)
                    begin
                        shadow_regs[c.dest] = '0;
                        r.div_zero = 1'b1;
                    end
                    else
                    begin
                        // 64-bit quotient keeps most-negative over minus one from trapping
                        quot = longint'($signed(va)) / longint'($signed(vb));
                        shadow_regs[c.dest] = quot[DATA_W-1:0];
                    end
                end
                OP_IN_A, OP_IN_B: shadow_regs[c.src_a] = c.user_value;
                OP_OUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_value = va;
                end
                OP_CLEAR: foreach (shadow_regs[i]) shadow_regs[i] = '0;
                OP_HALT:  shadow_halted = 1'b1;
                default:  ;
            endcase
        end
        r.halted = shadow_halted;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'($urandom_range(0, 31)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    // Mostly register writes, arithmetic and output; halt is left to the closing rows.
    function automatic cmd_t random_instr();
        int          pick;
        logic [3:0]  op;
        pick = $urandom_range(0, 99);
        if (pick < 13)      op = OP_IN_A;
        else if (pick < 26) op = OP_IN_B;
        else if (pick < 36) op = OP_LOADI;
        else if (pick < 44) op = OP_ADD;
        else if (pick < 52) op = OP_SUB;
        else if (pick < 60) op = OP_MUL;
        else if (pick < 74) op = OP_DIV;
        else if (pick < 94) op = OP_OUT;
        else if (pick < 96) op = OP_CLEAR;
        else                op = OP_SPARE[3'($urandom_range(0, 5))];
        return instr(op, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 63), pick_value());
    endfunction

    task automatic issue(input cmd_t c, input logic fixed, input rsp_t fixed_rsp);
        int   gap;
        rsp_t predicted;
        gap = calm_phase ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        predicted = exec_instruction(c);
        pending_results.push_back(fixed ? fixed_rsp : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected beat, out_value", rsp.out_value, '0);
            else
            begin
                oldest = pending_results.pop_front();
                if (rsp.out_valid !== oldest.out_valid)
                    flag_mismatch("out_valid", DATA_W'(rsp.out_valid),
                                  DATA_W'(oldest.out_valid));
                if (rsp.out_value !== oldest.out_value)
                    flag_mismatch("out_value", rsp.out_value, oldest.out_value);
                if (rsp.halted !== oldest.halted)
                    flag_mismatch("halted", DATA_W'(rsp.halted), DATA_W'(oldest.halted));
                if (rsp.div_zero !== oldest.div_zero)
                    flag_mismatch("div_zero", DATA_W'(rsp.div_zero),
                                  DATA_W'(oldest.div_zero));
            end
            results_seen++;
        end
    end

    // Result side: outside calm phases, stall at random before taking each beat.
    initial
    begin
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = calm_phase ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        mismatches    = 0;
        results_seen  = 0;
        calm_phase    = 1'b0;
        shadow_halted = 1'b0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;

        plan[0]  = '{instr(OP_OUT,   0, 0, 0,  0, '0),           1'b1, SHOW_ZERO};
        plan[1]  = '{instr(OP_DIV,   1, 2, 3,  0, '0),           1'b1, DIV_BY_ZERO};
        plan[2]  = '{instr(OP_LOADI, 0, 0, 1, 63, '0),           1'b0, '0};
        plan[3]  = '{instr(OP_IN_A,  4, 0, 0,  0, 32'h7FFF_FFFF), 1'b0, '0};
        plan[4]  = '{instr(OP_IN_B,  5, 0, 0,  0, 32'h8000_0000), 1'b0, '0};
        plan[5]  = '{instr(OP_ADD,   4, 4, 6,  0, '0),           1'b0, '0};
        plan[6]  = '{instr(OP_SUB,   5, 1, 7,  0, '0),           1'b0, '0};
        plan[7]  = '{instr(OP_MUL,   4, 5, 3,  0, '0),           1'b0, '0};
        plan[8]  = '{instr(OP_IN_A,  2, 0, 0,  0, 32'hFFFF_FFFF), 1'b0, '0};
        // most negative over minus one wraps back to most negative
        plan[9]  = '{instr(OP_DIV,   5, 2, 0,  0, '0),           1'b0, '0};
        plan[10] = '{instr(OP_OUT,   0, 0, 0,  0, '0),           1'b0, '0};
        plan[11] = '{instr(OP_DIV,   4, 2, 6,  0, '0),           1'b0, '0};
        plan[12] = '{instr(OP_OUT,   6, 7, 7, 63, 32'hFFFF_FFFF), 1'b0, '0};
        for (int k = 0; k < 6; k++)
            plan[13 + k] = '{instr(OP_SPARE[3'(k)], 7, 7, 7, 63, 32'hFFFF_FFFF), 1'b0, '0};
        plan[19] = '{instr(OP_OUT,   7, 0, 0,  0, '0),           1'b0, '0};
        plan[20] = '{instr(OP_CLEAR, 0, 0, 0,  0, '0),           1'b0, '0};
        plan[21] = '{instr(OP_OUT,   5, 0, 0,  0, '0),           1'b1, SHOW_ZERO};
        // closing rows: halt, then everything after it must do nothing
        plan[22] = '{instr(OP_HALT,  0, 0, 0,  0, '0),           1'b1, HALTED_ONLY};
        plan[23] = '{instr(OP_OUT,   1, 0, 0,  0, '0),           1'b1, HALTED_ONLY};
        plan[24] = '{instr(OP_DIV,   0, 0, 0,  0, '0),           1'b1, HALTED_ONLY};
        plan[25] = '{instr(OP_IN_B,  3, 0, 0,  0, 32'd1),        1'b1, HALTED_ONLY};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PRE; i++)
            issue(plan[i].c, plan[i].fixed, plan[i].want);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 64 == 0)
                calm_phase = ($urandom_range(0, 3) == 0);
            issue(random_instr(), 1'b0, '0);
        end
        calm_phase = 1'b0;
        for (int i = N_PRE; i < N_PLAN; i++)
            issue(plan[i].c, plan[i].fixed, plan[i].want);
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
